>>> hdl/sle_pkg.sv
// Shared constants for the serial line editor: operation codes, result kinds
// and the terminal byte values that the editor recognizes. No dependencies.
package sle_pkg;

  localparam int LINE_AW = 6;
  localparam int BYTE_W  = 8;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [2:0] KIND_ECHO = 3'd0;
  localparam logic [2:0] KIND_UP   = 3'd1;
  localparam logic [2:0] KIND_DOWN = 3'd2;
  localparam logic [2:0] KIND_TAB  = 3'd3;
  localparam logic [2:0] KIND_READ = 3'd4;

  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_UP      = 8'h41;
  localparam logic [7:0] CH_DOWN    = 8'h42;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_DEL     = 8'h7F;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [1:0] ESC_NONE    = 2'd0;
  localparam logic [1:0] ESC_SEEN    = 2'd1;
  localparam logic [1:0] ESC_BRACKET = 2'd2;

endpackage

>>> hdl/sle_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/serial_line_editor_unit.sv
// Serial line editor top level. Uses sle_pkg and the sle_ram line buffer.
// Control state sits in registers; the line characters sit in the RAM.

// Each transfer on the input is decoded in the cycle it is taken: escape state,
// line length and the command-ready flag update at once, a printable byte is
// written to the line RAM, and a read op launches a RAM read whose registered
// data is present when the result is shown. The results of one input (up to
// three: CR LF, or BS SP BS) leave through a single output register, one per
// cycle while the output does not stall; the next input is taken in the same
// cycle that the last result of the previous one transfers. The line RAM
// needs no clearing: positions at or beyond the current length read as zero.
module serial_line_editor_unit #(
  parameter int LINE_MAX = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [7:0] in_rx_byte,
  input  logic [5:0] in_read_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic       out_last,
  output logic [5:0] out_line_length,
  output logic       out_command_ready
);

  localparam int LimitInt = (LINE_MAX > 63) ? 63 : LINE_MAX;
  localparam logic [sle_pkg::LINE_AW-1:0] LIMIT = sle_pkg::LINE_AW'(LimitInt);
  localparam logic [sle_pkg::LINE_AW-1:0] COUNT_ONE = sle_pkg::LINE_AW'(1);

  typedef enum logic [2:0] {
    SEQ_UP,
    SEQ_DOWN,
    SEQ_TAB,
    SEQ_CRLF,
    SEQ_BS,
    SEQ_CHAR,
    SEQ_READ
  } seq_t;

  // Architectural state.
  logic [1:0]                  esc_r, esc_nxt;
  logic [sle_pkg::LINE_AW-1:0] count_r, count_nxt;
  logic                        ready_r, ready_nxt;

  // Output stage.
  logic                        stg_vld_r;
  seq_t                        stg_seq_r;
  logic [1:0]                  stg_nres_r;
  logic [1:0]                  stg_pos_r;
  logic [7:0]                  stg_char_r;
  logic                        stg_zero_r;
  logic [sle_pkg::LINE_AW-1:0] stg_len_r;
  logic                        stg_rdy_r;

  // Decode results.
  seq_t       dec_seq;
  logic [1:0] dec_nres;
  logic       ram_we;
  logic       ram_re;
  logic [7:0] ram_rdata;

  logic out_xfer;
  logic out_fin;
  logic in_xfer;

  assign out_xfer = out_valid && !out_stall;
  assign out_fin  = out_xfer && out_last;
  assign in_stall = stg_vld_r && !out_fin;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    esc_nxt   = esc_r;
    count_nxt = count_r;
    ready_nxt = ready_r;
    dec_seq   = SEQ_CHAR;
    dec_nres  = 2'd0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    case (in_op)
      sle_pkg::OP_BYTE: begin
        if (in_rx_byte == sle_pkg::CH_ESC) begin
          esc_nxt = sle_pkg::ESC_SEEN;
        end else if (esc_r == sle_pkg::ESC_SEEN) begin
          esc_nxt = (in_rx_byte == sle_pkg::CH_LBRACK) ? sle_pkg::ESC_BRACKET
                                                       : sle_pkg::ESC_NONE;
        end else if (esc_r == sle_pkg::ESC_BRACKET) begin
          esc_nxt = sle_pkg::ESC_NONE;
          if (in_rx_byte == sle_pkg::CH_UP) begin
            dec_seq  = SEQ_UP;
            dec_nres = 2'd1;
          end else if (in_rx_byte == sle_pkg::CH_DOWN) begin
            dec_seq  = SEQ_DOWN;
            dec_nres = 2'd1;
          end
        end else begin
          esc_nxt = sle_pkg::ESC_NONE;
          if (in_rx_byte inside {sle_pkg::CH_CR, sle_pkg::CH_LF}) begin
            ready_nxt = 1'b1;
            dec_seq   = SEQ_CRLF;
            dec_nres  = 2'd2;
          end else if (in_rx_byte == sle_pkg::CH_TAB) begin
            dec_seq  = SEQ_TAB;
            dec_nres = 2'd1;
          end else if (in_rx_byte inside {sle_pkg::CH_BS, sle_pkg::CH_DEL}) begin
            // Erased positions are never read back, so nothing is written.
            if (count_r != '0) begin
              count_nxt = count_r - COUNT_ONE;
              dec_seq   = SEQ_BS;
              dec_nres  = 2'd3;
            end
          end else if (count_r < LIMIT) begin
            count_nxt = count_r + COUNT_ONE;
            ram_we    = 1'b1;
            dec_seq   = SEQ_CHAR;
            dec_nres  = 2'd1;
          end
        end
      end
      sle_pkg::OP_CLEAR: begin
        count_nxt = '0;
        ready_nxt = 1'b0;
      end
      sle_pkg::OP_READ: begin
        ram_re   = 1'b1;
        dec_seq  = SEQ_READ;
        dec_nres = 2'd1;
      end
      default: begin
      end
    endcase
  end

  sle_ram #(
    .WIDTH(sle_pkg::BYTE_W),
    .DEPTH(1 << sle_pkg::LINE_AW)
  ) u_line_ram (
    .clk  (clk),
    .we   (in_xfer && ram_we),
    .waddr(count_r),
    .wdata(in_rx_byte),
    .re   (in_xfer && ram_re),
    .raddr(in_read_index),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r     <= sle_pkg::ESC_NONE;
      count_r   <= '0;
      ready_r   <= 1'b0;
      stg_vld_r <= 1'b0;
      stg_pos_r <= 2'd0;
    end else begin
      if (in_xfer) begin
        esc_r   <= esc_nxt;
        count_r <= count_nxt;
        ready_r <= ready_nxt;
      end
      if (in_xfer && dec_nres != 2'd0) begin
        stg_vld_r <= 1'b1;
        stg_pos_r <= 2'd0;
      end else if (out_fin) begin
        stg_vld_r <= 1'b0;
      end else if (out_xfer) begin
        stg_pos_r <= stg_pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && dec_nres != 2'd0) begin
      stg_seq_r  <= dec_seq;
      stg_nres_r <= dec_nres;
      stg_char_r <= in_rx_byte;
      stg_zero_r <= (in_read_index >= count_r);
      stg_len_r  <= count_nxt;
      stg_rdy_r  <= ready_nxt;
    end
  end

  always_comb begin
    out_kind      = sle_pkg::KIND_ECHO;
    out_data_byte = 8'h00;
    case (stg_seq_r)
      SEQ_UP:   out_kind = sle_pkg::KIND_UP;
      SEQ_DOWN: out_kind = sle_pkg::KIND_DOWN;
      SEQ_TAB:  out_kind = sle_pkg::KIND_TAB;
      SEQ_CRLF: out_data_byte = (stg_pos_r == 2'd0) ? sle_pkg::CH_CR : sle_pkg::CH_LF;
      SEQ_BS:   out_data_byte = (stg_pos_r == 2'd1) ? sle_pkg::CH_SPACE : sle_pkg::CH_BS;
      SEQ_CHAR: out_data_byte = stg_char_r;
      SEQ_READ: begin
        out_kind      = sle_pkg::KIND_READ;
        out_data_byte = stg_zero_r ? 8'h00 : ram_rdata;
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = stg_vld_r;
  assign out_last          = (stg_pos_r == stg_nres_r - 2'd1);
  assign out_line_length   = stg_len_r;
  assign out_command_ready = stg_rdy_r;

  a_count_limit : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LIMIT)
    else $error("line length exceeds limit");

  a_more_follow : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("result sequence ended without last");

  a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r |-> stg_pos_r < stg_nres_r)
    else $error("result position past result count");

  a_read_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op == sle_pkg::OP_READ |=>
      out_valid && out_kind == sle_pkg::KIND_READ && out_last)
    else $error("read op did not produce read result");

endmodule

>>> tb/sv/tb_serial_line_editor_unit.sv
// Self-checking testbench for serial_line_editor_unit: drives keystrokes and ops with
// random gaps, predicts every echo, event and read result, and checks them in order.
// Depends on sle_pkg and the serial_line_editor_unit RTL.
module tb_serial_line_editor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_LIMIT  = 63;
  localparam int LINE_CAP    = (LINE_LIMIT > 63) ? 63 : LINE_LIMIT;
  localparam int CYCLE_LIMIT = 20000;
  localparam int DRAIN_TAIL  = 20;
  localparam int BACKLOG_LEN = 200;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx;
    logic [5:0] idx;
  } keystroke_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
    logic [5:0] len;
    logic       ready;
  } editor_result_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_op = sle_pkg::OP_BYTE;
  logic [7:0] in_rx_byte = 8'h00;
  logic [5:0] in_read_index = 6'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_data_byte;
  logic       out_last;
  logic [5:0] out_line_length;
  logic       out_command_ready;

  keystroke_t     keystrokes_pending[$];
  editor_result_t results_due[$];

  // Shadow copy of the editor state.
  logic [1:0] seq_phase = sle_pkg::ESC_NONE;
  logic [7:0] line_chars [64] = '{default: 8'h00};
  logic [5:0] char_count = 6'd0;
  logic       cmd_ready = 1'b0;

  int mismatch_count = 0;
  int items_taken = 0;
  int cycle_count = 0;
  int hold_mark = 1 << 30;
  int backlog_cycles = 0;
  bit backlog_done = 1'b0;
  bit offer_taken = 1'b0;
  bit calm;

  assign calm = (items_taken >= 40) && (items_taken < 90);

  serial_line_editor_unit #(.LINE_MAX(LINE_LIMIT)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_rx_byte        (in_rx_byte),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_last          (out_last),
    .out_line_length   (out_line_length),
    .out_command_ready (out_command_ready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic edit_line_model(input logic [1:0] op, input logic [7:0] rx,
                                 input logic [5:0] idx);
    logic [2:0] kinds [3];
    logic [7:0] bytes_out [3];
    int n;
    n = 0;
    case (op)
      sle_pkg::OP_BYTE: begin
        if (rx == sle_pkg::CH_ESC) begin
          seq_phase = sle_pkg::ESC_SEEN;
        end else if (seq_phase == sle_pkg::ESC_SEEN) begin
          seq_phase = (rx == sle_pkg::CH_LBRACK) ? sle_pkg::ESC_BRACKET : sle_pkg::ESC_NONE;
        end else if (seq_phase == sle_pkg::ESC_BRACKET) begin
          if (rx == sle_pkg::CH_UP) begin
            kinds[0] = sle_pkg::KIND_UP;
            bytes_out[0] = 8'h00;
            n = 1;
          end else if (rx == sle_pkg::CH_DOWN) begin
            kinds[0] = sle_pkg::KIND_DOWN;
            bytes_out[0] = 8'h00;
            n = 1;
          end
          seq_phase = sle_pkg::ESC_NONE;
        end else begin
          seq_phase = sle_pkg::ESC_NONE;
          if (rx inside {sle_pkg::CH_CR, sle_pkg::CH_LF}) begin
            cmd_ready = 1'b1;
            kinds[0] = sle_pkg::KIND_ECHO;
            bytes_out[0] = sle_pkg::CH_CR;
            kinds[1] = sle_pkg::KIND_ECHO;
            bytes_out[1] = sle_pkg::CH_LF;
            n = 2;
          end else if (rx == sle_pkg::CH_TAB) begin
            kinds[0] = sle_pkg::KIND_TAB;
            bytes_out[0] = 8'h00;
            n = 1;
          end else if (rx inside {sle_pkg::CH_BS, sle_pkg::CH_DEL}) begin
            if (char_count != 6'd0) begin
              char_count = char_count - 6'd1;
              line_chars[char_count] = 8'h00;
              kinds[0] = sle_pkg::KIND_ECHO;
              bytes_out[0] = sle_pkg::CH_BS;
              kinds[1] = sle_pkg::KIND_ECHO;
              bytes_out[1] = sle_pkg::CH_SPACE;
              kinds[2] = sle_pkg::KIND_ECHO;
              bytes_out[2] = sle_pkg::CH_BS;
              n = 3;
            end
          end else if (char_count < LINE_CAP) begin
            line_chars[char_count] = rx;
            char_count = char_count + 6'd1;
            kinds[0] = sle_pkg::KIND_ECHO;
            bytes_out[0] = rx;
            n = 1;
          end
        end
      end
      sle_pkg::OP_CLEAR: begin
        foreach (line_chars[i]) line_chars[i] = 8'h00;
        char_count = 6'd0;
        cmd_ready = 1'b0;
      end
      sle_pkg::OP_READ: begin
        kinds[0] = sle_pkg::KIND_READ;
        bytes_out[0] = (idx < char_count) ? line_chars[idx] : 8'h00;
        n = 1;
      end
      default: ;
    endcase
    for (int k = 0; k < n; k++) begin
      results_due.push_back('{kind: kinds[k], data: bytes_out[k], last: (k == n - 1),
                              len: char_count, ready: cmd_ready});
    end
  endtask

  task automatic flag_mismatch(input string why, input editor_result_t want,
                               input editor_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch %0d (%s): expected kind=%0d data=%02h last=%0d len=%0d ready=%0d",
               mismatch_count, why, want.kind, want.data, want.last, want.len, want.ready);
      $display("    got kind=%0d data=%02h last=%0d len=%0d ready=%0d",
               got.kind, got.data, got.last, got.len, got.ready);
    end
  endtask

  task automatic queue_item(input logic [1:0] p_op, input logic [7:0] p_rx,
                            input logic [5:0] p_idx);
    keystrokes_pending.push_back('{op: p_op, rx: p_rx, idx: p_idx});
  endtask

  task automatic queue_byte(input logic [7:0] b);
    queue_item(sle_pkg::OP_BYTE, b, 6'($urandom));
  endtask

  task automatic queue_read(input logic [5:0] i);
    queue_item(sle_pkg::OP_READ, 8'($urandom), i);
  endtask

  task automatic queue_clear();
    queue_item(sle_pkg::OP_CLEAR, 8'($urandom), 6'($urandom));
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b inside {sle_pkg::CH_ESC, sle_pkg::CH_CR, sle_pkg::CH_LF, sle_pkg::CH_TAB,
                         sle_pkg::CH_BS, sle_pkg::CH_DEL});
    return b;
  endfunction

  // Mostly well-formed editing: typing, arrow sequences, erases, line ends, tabs,
  // reads and clears, with some broken sequences and fully random ops mixed in.
  task automatic queue_random_group(inout int counted);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      queue_byte(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : plain_byte());
      counted += 1;
    end else if (pick < 48) begin
      queue_byte(sle_pkg::CH_ESC);
      case ($urandom_range(0, 3))
        0: begin
          queue_byte(sle_pkg::CH_LBRACK);
          queue_byte(sle_pkg::CH_UP);
        end
        1: begin
          queue_byte(sle_pkg::CH_LBRACK);
          queue_byte(sle_pkg::CH_DOWN);
        end
        2: queue_byte(plain_byte());
        default: begin
          queue_byte(sle_pkg::CH_LBRACK);
          queue_byte(plain_byte());
        end
      endcase
      counted += 3;
    end else if (pick < 56) begin
      queue_byte($urandom_range(0, 1) ? sle_pkg::CH_BS : sle_pkg::CH_DEL);
      counted += 1;
    end else if (pick < 61) begin
      queue_byte($urandom_range(0, 1) ? sle_pkg::CH_CR : sle_pkg::CH_LF);
      counted += 1;
    end else if (pick < 65) begin
      queue_byte(sle_pkg::CH_TAB);
      counted += 1;
    end else if (pick < 79) begin
      queue_read($urandom_range(0, 1) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 15)));
      counted += 1;
    end else if (pick < 83) begin
      queue_clear();
      counted += 1;
    end else if (pick < 85) begin
      queue_item(2'd3, 8'($urandom), 6'($urandom));
    end else if (pick < 90) begin
      repeat (5) queue_byte(plain_byte());
      counted += 5;
    end else begin
      queue_item(2'($urandom_range(0, 3)), 8'($urandom), 6'($urandom));
      counted += 1;
    end
  endtask

  task automatic wait_drained();
    while (keystrokes_pending.size() != 0 || results_due.size() != 0) @(negedge clk);
  endtask

  // Sender: holds a stalled item, otherwise offers the next one unless idling.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || offer_taken) begin
      offer_taken = 1'b0;
      if (keystrokes_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 35)) begin
        in_valid      <= 1'b1;
        in_op         <= keystrokes_pending[0].op;
        in_rx_byte    <= keystrokes_pending[0].rx;
        in_read_index <= keystrokes_pending[0].idx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long backlog once enough items have gone in.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (backlog_cycles > 0) begin
      out_stall      <= 1'b1;
      backlog_cycles <= backlog_cycles - 1;
    end else if (!backlog_done && items_taken >= hold_mark) begin
      out_stall      <= 1'b1;
      backlog_cycles <= BACKLOG_LEN;
      backlog_done   <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 35);
    end
  end

  // Monitor: predicts on each input transfer, then checks each output transfer.
  always @(posedge clk) begin
    editor_result_t seen;
    editor_result_t due;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("serial_line_editor_unit regression: fail");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) begin
        edit_line_model(in_op, in_rx_byte, in_read_index);
        keystrokes_pending.delete(0);
        items_taken++;
        offer_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        seen = '{kind: out_kind, data: out_data_byte, last: out_last,
                 len: out_line_length, ready: out_command_ready};
        if (results_due.size() == 0) begin
          flag_mismatch("no result expected", '0, seen);
        end else begin
          due = results_due.pop_front();
          if (seen.kind !== due.kind || seen.data !== due.data || seen.last !== due.last ||
              seen.len !== due.len || seen.ready !== due.ready) begin
            flag_mismatch("field differs", due, seen);
          end
        end
      end
    end
  end

  initial begin
    int counted;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-line reads, unused op, erase on empty, byte extremes, tab,
    // restarted and dropped escape sequences, line ends, and clear inside a sequence.
    queue_read(6'd0);
    queue_read(6'd63);
    queue_item(2'd3, 8'hFF, 6'd63);
    queue_byte(sle_pkg::CH_BS);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(sle_pkg::CH_TAB);
    queue_byte(sle_pkg::CH_ESC);
    queue_byte(sle_pkg::CH_ESC);
    queue_byte(sle_pkg::CH_LBRACK);
    queue_byte(sle_pkg::CH_UP);
    queue_byte(sle_pkg::CH_ESC);
    queue_byte(8'h78);
    queue_byte(sle_pkg::CH_ESC);
    queue_byte(sle_pkg::CH_LBRACK);
    queue_byte(8'h43);
    queue_byte(sle_pkg::CH_DEL);
    queue_read(6'd0);
    queue_byte(sle_pkg::CH_CR);
    queue_byte(8'h61);
    queue_byte(sle_pkg::CH_LF);
    queue_byte(sle_pkg::CH_ESC);
    queue_clear();
    queue_byte(sle_pkg::CH_LBRACK);
    queue_byte(sle_pkg::CH_DOWN);
    queue_read(6'd0);
    wait_drained();

    counted = 0;
    while (counted < 50) queue_random_group(counted);
    // Fill the line past its limit, then read at the top and erase from full.
    repeat (LINE_CAP + 3) queue_byte(plain_byte());
    queue_read(6'(LINE_CAP - 1));
    queue_read(6'd63);
    queue_byte(sle_pkg::CH_BS);
    queue_read(6'(LINE_CAP - 1));
    queue_clear();
    // The sender stops here until every expected result has come back.
    wait_drained();

    hold_mark = items_taken + 25;
    counted = 0;
    while (counted < 70) queue_random_group(counted);
    wait_drained();

    repeat (DRAIN_TAIL) @(negedge clk);
    mismatch_count += results_due.size();
    if (mismatch_count == 0) begin
      $display("serial_line_editor_unit regression: pass");
    end else begin
      $display("serial_line_editor_unit regression: fail");
    end
    $finish;
  end

endmodule
